[hdl/ibanv_pkg.sv]
package ibanv_pkg;

    // Default table depths
    localparam int SPEC_ENTRIES_DEF = 64;
    localparam int PAIR_ENTRIES_DEF = 128;

    // Item function codes
    localparam logic [1:0] FUNC_SPEC = 2'd0;
    localparam logic [1:0] FUNC_PAIR = 2'd1;
    localparam logic [1:0] FUNC_CHAR = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_TOO_SHORT   = 3'd1;
    localparam logic [2:0] STAT_NO_PREFIX   = 3'd2;
    localparam logic [2:0] STAT_BAD_LENGTH  = 3'd3;
    localparam logic [2:0] STAT_NO_COUNTRY  = 3'd4;
    localparam logic [2:0] STAT_BAD_COUNTRY = 3'd5;
    localparam logic [2:0] STAT_BAD_CHECK   = 3'd6;

    // Spec entry layout: prefix, length, BIC start, BIC end
    localparam int SPEC_W = 34;
    localparam int PAIR_W = 32;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic        is_last;
        logic [15:0] country_code;
        logic [15:0] entry_prefix;
        logic [5:0]  entry_length;
        logic [5:0]  entry_bic_first;
        logic [5:0]  entry_bic_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] bic_first;
        logic [5:0] bic_end;
        logic       bic_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_SPEC,
        S_PAIR,
        S_FOLD,
        S_DONE
    } state_t;

    // Fold one character into a mod-97 remainder; bit 7 flags a bad character
    function automatic logic [7:0] fold_char(input logic [6:0] r, input logic [7:0] c);
        logic        is_dig;
        logic        is_let;
        logic [9:0]  x;
        logic [19:0] prod;
        logic [3:0]  q;
        logic [9:0]  qm;
        logic [9:0]  rr;
        is_dig = (c >= 8'h30) && (c <= 8'h39);
        is_let = (c >= 8'h41) && (c <= 8'h5A);
        // 100 mod 97 is 3, so a letter folds as 3r + value
        if (is_dig) begin
            x = {r, 3'b000} + {2'b00, r, 1'b0} + {2'b00, c - 8'h30};
        end else begin
            x = {3'b000, r} + {2'b00, r, 1'b0} + {2'b00, c - 8'h37};
        end
        // Exact quotient for x below 1024 via reciprocal
        prod = {10'd0, x} * 20'd676;
        q    = prod[19:16];
        qm   = {q, 6'b0} + {1'b0, q, 5'b0} + {6'd0, q};
        rr   = x - qm;
        if (is_dig || is_let) begin
            return {1'b0, rr[6:0]};
        end else begin
            return {1'b1, r};
        end
    endfunction

endpackage

[hdl/ibanv_ram.sv]
module ibanv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/iban_mod97_validator.sv]
// Channel | Ports                       | Moves
// input   | s_valid, s_ready, s_item    | table load or one IBAN character per item
// result  | m_valid, m_ready, m_item    | status and BIC span per finished IBAN
//
// Loads and non-final characters leave the block idle, ready for the next item;
// characters after the first four fold into the mod-97 remainder in their
// accept cycle, the first four are held as the head. A final character runs a
// finish step, table RAM scans reading one entry per cycle, and up to 4 head folds.
// Reset (aresetn low, synchronous) empties both tables and the IBAN state;
// table contents need no clearing, reads stay below the fill counts.
// A pending result waits in the output register; only a second finished IBAN
// stalls until it is taken.
module iban_mod97_validator #(
    parameter int SPEC_ENTRIES = ibanv_pkg::SPEC_ENTRIES_DEF,
    parameter int PAIR_ENTRIES = ibanv_pkg::PAIR_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ibanv_pkg::in_item_t s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ibanv_pkg::out_item_t m_item
);
    import ibanv_pkg::*;

    localparam int SAW = (SPEC_ENTRIES > 1) ? $clog2(SPEC_ENTRIES) : 1;
    localparam int PAW = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int SCW = $clog2(SPEC_ENTRIES + 1);
    localparam int PCW = $clog2(PAIR_ENTRIES + 1);
    localparam int IW  = (SCW > PCW) ? SCW : PCW;

    state_t            state_reg, state_next;
    logic [SCW-1:0]    spec_cnt_reg, spec_cnt_next;
    logic [PCW-1:0]    pair_cnt_reg, pair_cnt_next;
    logic [31:0]       head_reg, head_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [6:0]        rem_reg, rem_next;
    logic              bad_reg, bad_next;
    logic [15:0]       country_reg, country_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              ckey_reg, ckey_next;
    logic              cpair_reg, cpair_next;
    logic [1:0]        fidx_reg, fidx_next;
    logic [2:0]        status_reg, status_next;
    logic [5:0]        bs_reg, bs_next;
    logic [5:0]        be_reg, be_next;
    logic              bv_reg, bv_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              accept;
    logic [IW-1:0]     spec_cnt_ext;
    logic [IW-1:0]     pair_cnt_ext;
    logic [15:0]       prefix;
    logic              spec_we, spec_re, pair_we, pair_re;
    logic [SPEC_W-1:0] spec_wdata, spec_rdata;
    logic [PAIR_W-1:0] pair_wdata, pair_rdata;
    logic              spec_hit;
    logic              key_hit, pair_hit;
    logic [7:0]        char_fold, head_fold;
    logic [1:0]        fold_last;
    logic              spec_end, pair_end;
    logic              out_free;

    assign accept       = s_valid && s_ready;
    assign spec_cnt_ext = IW'(spec_cnt_reg);
    assign pair_cnt_ext = IW'(pair_cnt_reg);
    assign prefix       = {head_reg[7:0], head_reg[15:8]};
    assign spec_wdata   = {s_item.entry_prefix, s_item.entry_length,
                           s_item.entry_bic_first, s_item.entry_bic_end};
    assign pair_wdata   = {s_item.country_code, s_item.entry_prefix};
    assign spec_we      = accept && (s_item.func == FUNC_SPEC) &&
                          (spec_cnt_reg < SCW'(SPEC_ENTRIES));
    assign pair_we      = accept && (s_item.func == FUNC_PAIR) &&
                          (pair_cnt_reg < PCW'(PAIR_ENTRIES));
    assign spec_re      = (state_reg == S_SPEC) && (idx_reg < spec_cnt_ext);
    assign pair_re      = (state_reg == S_PAIR) && (idx_reg < pair_cnt_ext);
    assign spec_hit     = pend_reg && (spec_rdata[33:18] == prefix);
    assign key_hit      = pend_reg && (pair_rdata[31:16] == country_reg);
    assign pair_hit     = key_hit && (pair_rdata[15:0] == prefix);
    assign spec_end     = pend_reg && !spec_hit && (idx_reg >= spec_cnt_ext);
    assign pair_end     = pend_reg && (idx_reg >= pair_cnt_ext);
    assign char_fold    = fold_char(rem_reg, s_item.char_code);
    assign head_fold    = fold_char(rem_reg, head_reg[8*fidx_reg +: 8]);
    assign fold_last    = (cnt_reg >= 6'd4) ? 2'd3 : 2'(cnt_reg - 6'd1);
    assign out_free     = !out_valid_reg || m_ready;

    // Table memories; loads happen only while no scan runs, so no overlap
    ibanv_ram #(.WIDTH(SPEC_W), .DEPTH(SPEC_ENTRIES)) u_spec_ram (
        .aclk  (aclk),
        .we    (spec_we),
        .waddr (spec_cnt_reg[SAW-1:0]),
        .wdata (spec_wdata),
        .re    (spec_re),
        .raddr (idx_reg[SAW-1:0]),
        .rdata (spec_rdata)
    );

    ibanv_ram #(.WIDTH(PAIR_W), .DEPTH(PAIR_ENTRIES)) u_pair_ram (
        .aclk  (aclk),
        .we    (pair_we),
        .waddr (pair_cnt_reg[PAW-1:0]),
        .wdata (pair_wdata),
        .re    (pair_re),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (pair_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_item.func == FUNC_CHAR) && s_item.is_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (cnt_reg < 6'd2 || spec_cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SPEC;
                end
            end
            S_SPEC: begin
                if (spec_hit) begin
                    if (cnt_reg != spec_rdata[17:12]) begin
                        state_next = S_DONE;
                    end else if (country_reg == '0) begin
                        state_next = S_FOLD;
                    end else if (pair_cnt_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PAIR;
                    end
                end else if (spec_end) begin
                    state_next = S_DONE;
                end
            end
            S_PAIR: begin
                if (pair_end) begin
                    if (!(ckey_reg || key_hit) || !(cpair_reg || pair_hit)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                if (fidx_reg == fold_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and counters
    always_comb begin
        spec_cnt_next  = spec_cnt_reg;
        pair_cnt_next  = pair_cnt_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        bad_next       = bad_reg;
        country_next   = country_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        ckey_next      = ckey_reg;
        cpair_next     = cpair_reg;
        fidx_next      = fidx_reg;
        status_next    = status_reg;
        bs_next        = bs_reg;
        be_next        = be_reg;
        bv_next        = bv_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;

        // Drop a taken result
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (spec_we) begin
                    spec_cnt_next = spec_cnt_reg + 1'b1;
                end
                if (pair_we) begin
                    pair_cnt_next = pair_cnt_reg + 1'b1;
                end
                if (accept && s_item.func == FUNC_CHAR) begin
                    // Hold head characters, fold the rest
                    if (cnt_reg < 6'd4) begin
                        head_next[8*cnt_reg[1:0] +: 8] = s_item.char_code;
                        bad_next = bad_reg | char_fold[7];
                    end else begin
                        rem_next = char_fold[6:0];
                        bad_next = bad_reg | char_fold[7];
                    end
                    if (cnt_reg != 6'd63) begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                    country_next = s_item.country_code;
                end
            end
            S_FIN: begin
                idx_next  = '0;
                pend_next = 1'b0;
                fidx_next = '0;
                bs_next   = '0;
                be_next   = '0;
                bv_next   = 1'b0;
                if (cnt_reg < 6'd2) begin
                    status_next = STAT_TOO_SHORT;
                end else begin
                    status_next = STAT_NO_PREFIX;
                end
            end
            S_SPEC: begin
                // Issue the next read, compare the one returning
                if (spec_re) begin
                    idx_next = idx_reg + 1'b1;
                end
                pend_next = spec_re;
                if (spec_hit) begin
                    bs_next    = spec_rdata[11:6];
                    be_next    = spec_rdata[5:0];
                    bv_next    = 1'b1;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    ckey_next  = 1'b0;
                    cpair_next = 1'b0;
                    if (cnt_reg != spec_rdata[17:12]) begin
                        status_next = STAT_BAD_LENGTH;
                    end else begin
                        status_next = STAT_NO_COUNTRY;
                    end
                end
            end
            S_PAIR: begin
                if (pair_re) begin
                    idx_next = idx_reg + 1'b1;
                end
                pend_next  = pair_re;
                ckey_next  = ckey_reg | key_hit;
                cpair_next = cpair_reg | pair_hit;
                if (pair_end) begin
                    if (!(ckey_reg || key_hit)) begin
                        status_next = STAT_NO_COUNTRY;
                    end else if (!(cpair_reg || pair_hit)) begin
                        status_next = STAT_BAD_COUNTRY;
                    end
                end
            end
            S_FOLD: begin
                // Fold country letters and check digits, one per cycle
                rem_next  = head_fold[6:0];
                bad_next  = bad_reg | head_fold[7];
                fidx_next = fidx_reg + 2'd1;
                if (bad_reg || head_fold[7] || head_fold[6:0] != 7'd1) begin
                    status_next = STAT_BAD_CHECK;
                end else begin
                    status_next = STAT_OK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_item_next.status    = status_reg;
                    out_item_next.bic_first = bs_reg;
                    out_item_next.bic_end   = be_reg;
                    out_item_next.bic_valid = bv_reg;
                    out_valid_next          = 1'b1;
                    head_next               = '0;
                    cnt_next                = '0;
                    rem_next                = '0;
                    bad_next                = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            spec_cnt_reg  <= '0;
            pair_cnt_reg  <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            bad_reg       <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            ckey_reg      <= 1'b0;
            cpair_reg     <= 1'b0;
            fidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            spec_cnt_reg  <= spec_cnt_next;
            pair_cnt_reg  <= pair_cnt_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            bad_reg       <= bad_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            ckey_reg      <= ckey_next;
            cpair_reg     <= cpair_next;
            fidx_reg      <= fidx_next;
            out_valid_reg <= out_valid_next;
        end
        country_reg  <= country_next;
        status_reg   <= status_next;
        bs_reg       <= bs_next;
        be_reg       <= be_next;
        bv_reg       <= bv_next;
        out_item_reg <= out_item_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_spec_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        spec_cnt_reg <= SCW'(SPEC_ENTRIES))
        else $error("spec count beyond table depth");

    a_pair_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_cnt_reg <= PCW'(PAIR_ENTRIES))
        else $error("pair count beyond table depth");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done step");

    a_fold_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FOLD) |-> (cnt_reg >= 6'd2))
        else $error("head fold on too short IBAN");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (spec_we || pair_we) |-> (state_reg == S_IDLE))
        else $error("table write during scan");

endmodule
